// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the cycle permuter.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ipcp_pkg.sv
// Package for the in-place cycle permuter: field widths and parameter defaults.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ipcp_pkg;

  // Fixed widths of the channel fields
  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 6;

  // Defaults for the top-level parameters
  localparam int IPCP_MAX_LENGTH   = 64;
  localparam int IPCP_ELEMENT_BITS = 32;

endpackage

`default_nettype wire

// File: design/ipcp_in_if.sv
// Load channel of the cycle permuter: one vector element per beat.
// Depends on ipcp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ipcp_in_if import ipcp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_BITS-1:0] element_value;
  logic        [POS_BITS-1:0]   source_position;
  logic                        final_element;

  modport source (
    output valid, element_value, source_position, final_element,
    input  ready
  );

  modport sink (
    input  valid, element_value, source_position, final_element,
    output ready
  );
endinterface

`default_nettype wire

// File: design/ipcp_out_if.sv
// Result channel of the cycle permuter: one reordered element per beat.
// Depends on ipcp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ipcp_out_if import ipcp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_BITS-1:0] result_value;
  logic        [POS_BITS-1:0]   result_position;
  logic                        run_end;
  logic                        map_error;

  modport source (
    output valid, result_value, result_position, run_end, map_error,
    input  ready
  );

  modport sink (
    input  valid, result_value, result_position, run_end, map_error,
    output ready
  );
endinterface

`default_nettype wire

// File: design/in_place_cycle_permuter.sv
// Top level of the in-place cycle permuter: load, map check, cycle walk, emit.
// Depends on ipcp_pkg, ipcp_in_if, ipcp_out_if and assert_macros.svh.
//
//   channel   dir   beat                          payload
//   element   in    one vector element            element_value, source_position,
//                                                 final_element
//   result    out   one reordered element         result_value, result_position,
//                                                 run_end, map_error
//
// The map check runs alongside the load, as each element is taken.
// The walk uses one value/map memory pair with one read and one write port:
// each start position is read (S_RDS) and checked (S_CHK), and a position not yet in
// place starts a chain of moves (S_MOV) along its cycle, closed at S_END.
// Emit follows via S_PRE and gives one beat per cycle while result.ready is high.
// element.ready is high only in the load state; result stalls hold the run.
// rst is synchronous; it clears the seen marks and counters.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module in_place_cycle_permuter import ipcp_pkg::*; #(
  parameter int MAX_LENGTH   = IPCP_MAX_LENGTH,
  parameter int ELEMENT_BITS = IPCP_ELEMENT_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ipcp_in_if.sink    element,
  ipcp_out_if.source result
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int W  = ELEMENT_BITS;

  localparam logic [CW-1:0]       MAX_CNT = CW'(MAX_LENGTH);
  localparam logic [POS_BITS:0]   MAX_EXT = (POS_BITS + 1)'(MAX_LENGTH);

  // Sequencer states
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RDS  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MOV  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;
  localparam logic [2:0] S_PRE  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;
  localparam logic [2:0] S_ERR  = 3'd7;

  // Control state
  logic [2:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         n;
  logic                  err;
  logic                  dup;
  logic [POS_BITS-1:0]   maxs;
  logic [MAX_LENGTH-1:0] seen;

  // Walk and emit registers
  logic [AW-1:0] start;
  logic [AW-1:0] dest;
  logic [AW-1:0] src;
  logic [AW-1:0] pos;
  logic [W-1:0]  held;

  // Memories and registered read data
  logic [W-1:0]  val_mem [MAX_LENGTH];
  logic [AW-1:0] map_mem [MAX_LENGTH];
  logic [W-1:0]  rd_val;
  logic [AW-1:0] rd_map;

  // Memory port controls
  logic          we;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wval;
  logic [AW-1:0] wmap;
  logic          re;
  logic [AW-1:0] raddr;

  // Load-side decode
  logic                in_beat;
  logic                out_beat;
  logic                stored;
  logic                in_range;
  logic                hit;
  logic                dup_next;
  logic                err_next;
  logic [POS_BITS-1:0] max_next;
  logic [CW-1:0]       n_next;
  logic                map_ok;
  logic                start_last;
  logic                pos_last;

  assign in_beat  = element.valid && element.ready;
  assign out_beat = result.valid && result.ready;

  // Check the map while it loads: duplicates via seen marks, range via max
  always_comb begin
    stored   = count < MAX_CNT;
    in_range = {1'b0, element.source_position} < MAX_EXT;
    hit      = in_range && seen[element.source_position[AW-1:0]];
    dup_next = dup || (stored && hit);
    err_next = err || !stored;
    max_next = (stored && (element.source_position > maxs)) ?
               element.source_position : maxs;
    n_next   = stored ? count + CW'(1) : count;
    map_ok   = !err_next && !dup_next &&
               ({1'b0, max_next} < (POS_BITS + 1)'(n_next));
  end

  assign start_last = (CW'(start) + CW'(1)) == n;
  assign pos_last   = (CW'(pos) + CW'(1)) == n;

  // Select the memory write for load and walk
  always_comb begin
    we    = 1'b0;
    waddr = dest;
    wval  = rd_val;
    wmap  = dest;
    unique case (state)
      S_LOAD: begin
        if (in_beat && stored) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wval  = W'($unsigned(element.element_value));
          wmap  = element.source_position[AW-1:0];
        end
      end
      S_MOV: we = 1'b1;
      S_END: begin
        we   = 1'b1;
        wval = held;
      end
      default: we = 1'b0;
    endcase
  end

  // Select the memory read for walk and emit
  always_comb begin
    re    = 1'b0;
    raddr = start;
    unique case (state)
      S_RDS: re = 1'b1;
      S_CHK, S_MOV: begin
        raddr = rd_map;
        re    = rd_map != start;
      end
      S_PRE: begin
        raddr = '0;
        re    = 1'b1;
      end
      S_EMIT: begin
        raddr = pos + AW'(1);
        re    = out_beat && !pos_last;
      end
      default: re = 1'b0;
    endcase
  end

  // Value and map memories
  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wval;
      map_mem[waddr] <= wmap;
    end
    if (re) begin
      rd_val <= val_mem[raddr];
      rd_map <= map_mem[raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      err   <= 1'b0;
      dup   <= 1'b0;
      maxs  <= '0;
      seen  <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (element.final_element) begin
              // End the load: latch length, clear the check state
              n     <= n_next;
              count <= '0;
              err   <= 1'b0;
              dup   <= 1'b0;
              maxs  <= '0;
              seen  <= '0;
              start <= '0;
              state <= map_ok ? S_RDS : S_ERR;
            end else begin
              count <= n_next;
              err   <= err_next;
              dup   <= dup_next;
              maxs  <= max_next;
              if (stored && in_range) begin
                seen[element.source_position[AW-1:0]] <= 1'b1;
              end
            end
          end
        end
        S_RDS: state <= S_CHK;
        S_CHK: begin
          if (rd_map == start) begin
            // Position already in place: advance to the next start
            if (start_last) begin
              state <= S_PRE;
            end else begin
              start <= start + AW'(1);
              state <= S_RDS;
            end
          end else begin
            held  <= rd_val;
            dest  <= start;
            src   <= rd_map;
            state <= S_MOV;
          end
        end
        S_MOV: begin
          // Move the source value into dest, then follow the cycle
          dest <= src;
          src  <= rd_map;
          if (rd_map == start) begin
            state <= S_END;
          end
        end
        S_END: begin
          if (start_last) begin
            state <= S_PRE;
          end else begin
            start <= start + AW'(1);
            state <= S_RDS;
          end
        end
        S_PRE: begin
          pos   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_beat) begin
            if (pos_last) begin
              state <= S_LOAD;
            end else begin
              pos <= pos + AW'(1);
            end
          end
        end
        S_ERR: begin
          if (out_beat) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Drive the channels
  assign element.ready          = state == S_LOAD;
  assign result.valid           = (state == S_EMIT) || (state == S_ERR);
  assign result.result_value    = (state == S_EMIT) ? VALUE_BITS'(rd_val) : '0;
  assign result.result_position = (state == S_EMIT) ? POS_BITS'(pos) : '0;
  assign result.run_end         = (state == S_ERR) || pos_last;
  assign result.map_error       = state == S_ERR;

  // Checks
  `ASSERT_SAME(a_no_load_while_out, element.ready, !result.valid,
    "load accepted while results are pending")
  `ASSERT_NEXT(a_busy_after_final, in_beat && element.final_element, !element.ready,
    "block still ready after the final element")
  `ASSERT_SAME(a_walk_addr_apart, state == S_MOV, dest != src,
    "walk reads and writes the same position")
  `ASSERT_SAME(a_emit_in_range, state == S_EMIT, CW'(pos) < n,
    "emit position beyond the vector length")
  `ASSERT_SAME(a_count_bound, element.ready, count <= MAX_CNT,
    "load count beyond the maximum length")

endmodule

`default_nettype wire

// File: tb/tb_in_place_cycle_permuter.sv
// Self-checking testbench for in_place_cycle_permuter: loads vectors with index maps
// and checks each emitted beat against a scoreboard model of the reordering.
// Depends on ipcp_pkg, ipcp_in_if, ipcp_out_if and the in_place_cycle_permuter RTL.
`timescale 1ns / 1ps

module tb_in_place_cycle_permuter import ipcp_pkg::*; ();

  localparam int MAX_LENGTH       = IPCP_MAX_LENGTH;
  localparam int TOTAL_ITEMS      = 370;
  localparam int MAX_GAP          = 6;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int END_DRAIN_CYCLES = 200;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int VEC_SLOTS        = 80;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   position;
    logic                  run_end;
    logic                  map_error;
  } result_beat_t;

  typedef enum int {
    VEC_PERMUTATION,
    VEC_DUPLICATE,
    VEC_OUT_OF_RANGE,
    VEC_NOISE,
    VEC_OVERFLOW
  } vector_kind_t;

  // Scoreboard: mirrors the load buffer and queues the reordered run per vector
  class permute_scoreboard;
    logic [VALUE_BITS-1:0] load_values[MAX_LENGTH];
    logic [POS_BITS-1:0]   load_sources[MAX_LENGTH];
    int unsigned           load_count;
    bit                    overflow;
    result_beat_t          expected_q[$];
    int unsigned           fail_count;
    int unsigned           checked_count;
    int unsigned           loaded_beats;
    int unsigned           good_runs;
    int unsigned           error_runs;

    function new();
      load_count    = 0;
      overflow      = 1'b0;
      fail_count    = 0;
      checked_count = 0;
      loaded_beats  = 0;
      good_runs     = 0;
      error_runs    = 0;
    endfunction

    function void note_element(logic [VALUE_BITS-1:0] v, logic [POS_BITS-1:0] s, logic last);
      bit           seen[MAX_LENGTH];
      bit           map_ok;
      int unsigned  n;
      result_beat_t beat;
      loaded_beats++;
      // Store while there is room; drop and flag once the buffer is full
      if (load_count < MAX_LENGTH) begin
        load_values[load_count]  = v;
        load_sources[load_count] = s;
        load_count++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      n      = load_count;
      map_ok = !overflow;
      foreach (seen[k]) seen[k] = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (load_sources[i] >= n || seen[load_sources[i]]) map_ok = 1'b0;
        else seen[load_sources[i]] = 1'b1;
      end
      load_count = 0;
      overflow   = 1'b0;
      if (!map_ok) begin
        beat = '{value: '0, position: '0, run_end: 1'b1, map_error: 1'b1};
        expected_q.push_back(beat);
        error_runs++;
        return;
      end
      // A valid map gives out[i] = in[source[i]], emitted in position order
      for (int i = 0; i < n; i++) begin
        beat.value     = load_values[load_sources[i]];
        beat.position  = i[POS_BITS-1:0];
        beat.run_end   = (i == n - 1);
        beat.map_error = 1'b0;
        expected_q.push_back(beat);
      end
      good_runs++;
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked_count++;
      if (want.value !== got.value) begin
        fail_count++;
        $display("%0t ns: result_value mismatch, expected %h, actual %h",
                 $time, want.value, got.value);
      end
      if (want.position !== got.position) begin
        fail_count++;
        $display("%0t ns: result_position mismatch, expected %0d, actual %0d",
                 $time, want.position, got.position);
      end
      if (want.run_end !== got.run_end) begin
        fail_count++;
        $display("%0t ns: run_end mismatch, expected %b, actual %b",
                 $time, want.run_end, got.run_end);
      end
      if (want.map_error !== got.map_error) begin
        fail_count++;
        $display("%0t ns: map_error mismatch, expected %b, actual %b",
                 $time, want.map_error, got.map_error);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ipcp_in_if  elem_ch ();
  ipcp_out_if res_ch ();

  in_place_cycle_permuter u_top (
    .clk     (clk),
    .rst     (rst),
    .element (elem_ch),
    .result  (res_ch)
  );

  permute_scoreboard sb = new();

  logic [VALUE_BITS-1:0] vec_values[VEC_SLOTS];
  logic [POS_BITS-1:0]   vec_sources[VEC_SLOTS];
  int unsigned           items_sent;
  int unsigned           vectors_sent;
  int unsigned           idle_cycles;
  bit                    send_quiet;
  bit                    recv_quiet;
  bit                    hold_request;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Value source: mostly random, sometimes the extremes
  function automatic logic [VALUE_BITS-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
      1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Build a vector of the given kind into the staging arrays
  function automatic void fill_vector(vector_kind_t kind, int n);
    int j;
    int k;
    logic [POS_BITS-1:0] tmp;
    for (int i = 0; i < n; i++) begin
      vec_values[i]  = random_value();
      vec_sources[i] = i[POS_BITS-1:0];
    end
    if (kind == VEC_NOISE || kind == VEC_OVERFLOW) begin
      for (int i = 0; i < n; i++) vec_sources[i] = POS_BITS'($urandom_range(0, 63));
      return;
    end
    // Shuffle the identity map
    for (int i = n - 1; i > 0; i--) begin
      j              = $urandom_range(0, i);
      tmp            = vec_sources[i];
      vec_sources[i] = vec_sources[j];
      vec_sources[j] = tmp;
    end
    if (kind == VEC_DUPLICATE) begin
      j              = $urandom_range(0, n - 1);
      k              = (j + 1 + $urandom_range(0, n - 2)) % n;
      vec_sources[k] = vec_sources[j];
    end else if (kind == VEC_OUT_OF_RANGE) begin
      vec_sources[$urandom_range(0, n - 1)] = POS_BITS'($urandom_range(n, 63));
    end
  endfunction

  // Offer one element beat; valid stays high across back-to-back beats
  task automatic send_element(logic [VALUE_BITS-1:0] v, logic [POS_BITS-1:0] s, logic last);
    int gap;
    if ($urandom_range(0, 23) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_ch.valid           <= 1'b1;
    elem_ch.element_value   <= v;
    elem_ch.source_position <= s;
    elem_ch.final_element   <= last;
    do @(posedge clk); while (!elem_ch.ready);
    sb.note_element(v, s, last);
    items_sent++;
  endtask

  // Send the staged vector, flagging its last element
  task automatic send_staged(int n);
    for (int i = 0; i < n; i++) send_element(vec_values[i], vec_sources[i], i == n - 1);
    vectors_sent++;
  endtask

  // Drop valid and hold the sender until every expected beat has come back
  task automatic wait_drained();
    elem_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    recv_quiet   = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) recv_quiet = !recv_quiet;
      gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_request) begin
        gap          = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      sb.check_result('{value: res_ch.result_value, position: res_ch.result_position,
                        run_end: res_ch.run_end, map_error: res_ch.map_error});
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("in_place_cycle_permuter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int           n;
    int           pick;
    vector_kind_t kind;
    rst                     <= 1'b1;
    elem_ch.valid           <= 1'b0;
    elem_ch.element_value   <= '0;
    elem_ch.source_position <= '0;
    elem_ch.final_element   <= 1'b0;
    items_sent   = 0;
    vectors_sent = 0;
    send_quiet   = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: swap of the extreme values
    vec_values[0] = {1'b1, {(VALUE_BITS-1){1'b0}}}; vec_sources[0] = POS_BITS'(1);
    vec_values[1] = {1'b0, {(VALUE_BITS-1){1'b1}}}; vec_sources[1] = POS_BITS'(0);
    send_staged(2);
    // Single element vector
    vec_values[0] = '1; vec_sources[0] = POS_BITS'(0);
    send_staged(1);
    // Duplicated index
    vec_values[0] = 32'h1111_1111; vec_sources[0] = POS_BITS'(0);
    vec_values[1] = 32'h2222_2222; vec_sources[1] = POS_BITS'(0);
    vec_values[2] = 32'h3333_3333; vec_sources[2] = POS_BITS'(2);
    send_staged(3);
    // Index equal to the length and the top index
    vec_values[0] = 32'h0000_0001; vec_sources[0] = POS_BITS'(0);
    vec_values[1] = 32'hdead_beef; vec_sources[1] = POS_BITS'(3);
    vec_values[2] = 32'hcafe_f00d; vec_sources[2] = POS_BITS'(63);
    send_staged(3);
    // Identity map
    for (int i = 0; i < 3; i++) begin
      vec_values[i] = random_value(); vec_sources[i] = i[POS_BITS-1:0];
    end
    send_staged(3);
    // Single rotation cycle
    for (int i = 0; i < 4; i++) begin
      vec_values[i] = random_value(); vec_sources[i] = POS_BITS'((i + 1) % 4);
    end
    send_staged(4);
    // Reversal: two swaps and a fixed point
    for (int i = 0; i < 5; i++) begin
      vec_values[i] = random_value(); vec_sources[i] = POS_BITS'(4 - i);
    end
    send_staged(5);

    // Pause until the directed runs are out, then fill the block behind a held output
    wait_drained();
    hold_request = 1'b1;
    fill_vector(VEC_PERMUTATION, MAX_LENGTH);
    send_staged(MAX_LENGTH);
    fill_vector(VEC_OVERFLOW, MAX_LENGTH + 2);
    send_staged(MAX_LENGTH + 2);

    // Random vectors, mostly valid permutations
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        kind = VEC_PERMUTATION;  n = $urandom_range(1, 12);
      end else if (pick < 72) begin
        kind = VEC_PERMUTATION;  n = $urandom_range(13, MAX_LENGTH);
      end else if (pick < 82) begin
        kind = VEC_DUPLICATE;    n = $urandom_range(2, 12);
      end else if (pick < 92) begin
        kind = VEC_OUT_OF_RANGE; n = $urandom_range(1, 12);
      end else begin
        kind = VEC_NOISE;        n = $urandom_range(1, 8);
      end
      fill_vector(kind, n);
      send_staged(n);
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
    elem_ch.valid <= 1'b0;

    // Drain, then allow for stray beats
    wait_drained();
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    $display("Loaded %0d element beats in %0d vectors, emitting %0d result beats.",
             sb.loaded_beats, vectors_sent, sb.checked_count);
    $display("Runs: %0d reordered, %0d rejected for a bad map or overflow.",
             sb.good_runs, sb.error_runs);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("in_place_cycle_permuter regression: pass");
    end else begin
      $display("in_place_cycle_permuter regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/ipcp_pkg.sv
design/ipcp_in_if.sv
design/ipcp_out_if.sv
design/in_place_cycle_permuter.sv
tb/tb_in_place_cycle_permuter.sv
